// ===== src/motor_encoder_multiturn_tracker_defines.svh =====
// Assertion macros used by the checker file of the encoder tracker.
// No dependencies; included by bare file name.
`ifndef MOTOR_ENCODER_MULTITURN_TRACKER_DEFINES_SVH
`define MOTOR_ENCODER_MULTITURN_TRACKER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEMT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEMT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/memt_pkg.sv =====
// Shared constants for the multi-turn encoder tracker.
// No dependencies; used by the top level and its checker.
package memt_pkg;

   localparam int AVERAGE_DEPTH_DEF = 5;
   localparam int AVERAGE_DEPTH_MAX = 32;

   localparam int ANGLE_W   = 13;
   localparam int SPEED_W   = 16;
   localparam int RATE_W    = 14;
   localparam int COUNT_W   = 32;
   localparam int CAL_W     = 8;
   localparam int CSR_DW    = 32;
   localparam int CSR_AW    = 3;

   localparam logic [CAL_W-1:0] CAL_RESET     = 8'd51;
   localparam logic [CAL_W-1:0] MSG_COUNT_MAX = 8'd255;

   // Half a turn in encoder counts; a larger jump is a wrap.
   localparam int HALF_TURN = 4096;
   localparam int FULL_TURN = 8192;
   localparam int DEG_SHIFT = 13;
   localparam int DEG_SCALE = 360;

   // Register index, taken from address bit 2.
   typedef enum logic {
      CSR_CALIBRATION = 1'b0,
      CSR_UNUSED      = 1'b1
   } csr_index_type;

endpackage

// ===== src/motor_encoder_multiturn_tracker.sv =====
// Top level of the multi-turn encoder tracker: input register, update logic,
// result register and the APB-style register port. Depends on memt_pkg.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_angle_raw, req_speed_raw
//   rsp      out        rsp_valid / rsp_stall  rsp_calibrating .. rsp_filtered_rate
//   csr      in/out     psel/penable/pready    paddr, pwdata, prdata
//
// Every transfer on req gives exactly one transfer on rsp, through the input register
// and then the result register; one transfer is taken every cycle req does not stall.
// The rate is set by the single state update per cycle in the result stage.
// Reset is synchronous: both stages empty, tracking state and the average
// ring cleared, and the calibration count back to 51.
// A stall on rsp holds the result register; req stalls only when both
// stages are full and the result is not being taken.
module motor_encoder_multiturn_tracker #(
   parameter int AVERAGE_DEPTH = memt_pkg::AVERAGE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [memt_pkg::ANGLE_W-1:0]   req_angle_raw,
   input  logic signed [memt_pkg::SPEED_W-1:0]   req_speed_raw,
   // Result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_calibrating,
   output logic signed [memt_pkg::SPEED_W-1:0]   rsp_last_speed,
   output logic signed [memt_pkg::RATE_W-1:0]    rsp_step_rate,
   output logic signed [memt_pkg::COUNT_W-1:0]   rsp_turn_count,
   output logic signed [memt_pkg::COUNT_W-1:0]   rsp_total_count,
   output logic signed [memt_pkg::COUNT_W-1:0]   rsp_total_degrees,
   output logic signed [memt_pkg::RATE_W-1:0]    rsp_filtered_rate,
   // Register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic        [memt_pkg::CSR_AW-1:0]    paddr,
   input  logic        [memt_pkg::CSR_DW-1:0]    pwdata,
   output logic        [memt_pkg::CSR_DW-1:0]    prdata,
   output logic                                  pready
);

   // The ring pointer needs at least one bit even for a depth of one.
   localparam int PTR_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(AVERAGE_DEPTH - 1);

   // The running sum of the ring holds up to AVERAGE_DEPTH * 4096 in magnitude.
   localparam int LOG_D = $clog2(AVERAGE_DEPTH);
   localparam int SUM_W = memt_pkg::RATE_W + LOG_D;

   // Division of the sum magnitude by the depth is a multiplication by a
   // rounded-up reciprocal; with SUM_W + LOG_D fraction bits it is exact for
   // every magnitude below 2**SUM_W.
   localparam int RCP_SH = SUM_W + LOG_D;
   localparam int RCP_W  = SUM_W + 1;
   localparam logic [RCP_W-1:0] RCP_MUL =
      RCP_W'(((64'd1 << RCP_SH) + 64'(AVERAGE_DEPTH) - 64'd1) / 64'(AVERAGE_DEPTH));
   localparam int PROD_W = SUM_W + RCP_W;

   localparam int DEG_W = memt_pkg::COUNT_W + 10;

   localparam int AW = memt_pkg::ANGLE_W;
   localparam int RW = memt_pkg::RATE_W;
   localparam int CW = memt_pkg::COUNT_W;

   // ---------------------------------------------------------------------
   // Register port. pready is always high, so a write completes in its
   // access phase. Address bit 2 selects the register.
   // ---------------------------------------------------------------------
   logic [memt_pkg::CAL_W-1:0] cal_msgs_ff;
   logic                       csr_write;
   memt_pkg::csr_index_type    csr_index;

   assign pready    = 1'b1;
   assign csr_index = memt_pkg::csr_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_msgs_ff <= memt_pkg::CAL_RESET;
      end else if (csr_write && (csr_index == memt_pkg::CSR_CALIBRATION)) begin
         cal_msgs_ff <= pwdata[memt_pkg::CAL_W-1:0];
      end
   end

   always_comb begin
      case (csr_index)
         memt_pkg::CSR_CALIBRATION:
            prdata = {{(memt_pkg::CSR_DW - memt_pkg::CAL_W){1'b0}}, cal_msgs_ff};
         default:
            prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Handshake. The result stage moves whenever its register is empty or
   // being taken; the input register then refills in the same cycle.
   // ---------------------------------------------------------------------
   logic                              s1_valid_ff;
   logic        [AW-1:0]              s1_angle_ff;
   logic signed [memt_pkg::SPEED_W-1:0] s1_speed_ff;
   logic                              rsp_valid_ff;
   logic                              out_free;
   logic                              s1_load;
   logic                              update;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_load   = !s1_valid_ff || out_free;
   assign update    = s1_valid_ff && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         s1_angle_ff <= req_angle_raw;
         s1_speed_ff <= req_speed_raw;
      end
   end

   // ---------------------------------------------------------------------
   // Tracking state.
   // ---------------------------------------------------------------------
   logic        [memt_pkg::CAL_W-1:0]   msg_count_ff, msg_count_in;
   logic        [AW-1:0]                cur_angle_ff, cur_angle_in;
   logic        [AW-1:0]                off_angle_ff, off_angle_in;
   logic        [CW-1:0]                turns_ff, turns_in;
   logic signed [memt_pkg::SPEED_W-1:0] last_speed_ff, last_speed_in;
   logic        [PTR_W-1:0]             ptr_ff, ptr_in;
   logic signed [SUM_W-1:0]             sum_ff, sum_in;
   logic signed [RW-1:0]                ring_ff [AVERAGE_DEPTH];

   logic                calib;
   logic signed [AW:0]  diff;
   logic signed [RW-1:0] rate;
   logic [CW-1:0]       total;
   logic signed [DEG_W-1:0] deg_prod;
   logic signed [DEG_W-1:0] deg_biased;
   logic [CW-1:0]       degrees;
   logic [SUM_W-1:0]    sum_mag;
   logic [PROD_W-1:0]   avg_prod;
   logic [RW-1:0]       avg_mag;
   logic signed [RW-1:0] avg;

   always_comb begin
      calib = msg_count_ff < cal_msgs_ff;

      msg_count_in = (msg_count_ff == memt_pkg::MSG_COUNT_MAX) ?
                     msg_count_ff : msg_count_ff + 1'b1;

      // Angle step, unwrapped to the nearer direction. A step of exactly
      // half a turn is taken as it stands.
      diff = $signed({1'b0, s1_angle_ff}) - $signed({1'b0, cur_angle_ff});
      if (diff > $signed((AW+1)'(memt_pkg::HALF_TURN))) begin
         rate     = RW'(diff - $signed((AW+1)'(memt_pkg::FULL_TURN)));
         turns_in = turns_ff - 1'b1;
      end else if (diff < -$signed((AW+1)'(memt_pkg::HALF_TURN))) begin
         rate     = RW'(diff + $signed((AW+1)'(memt_pkg::FULL_TURN)));
         turns_in = turns_ff + 1'b1;
      end else begin
         rate     = RW'(diff);
         turns_in = turns_ff;
      end

      cur_angle_in  = s1_angle_ff;
      ptr_in        = (ptr_ff == PTR_LAST) ? '0 : ptr_ff + 1'b1;
      sum_in        = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(rate);
      last_speed_in = s1_speed_ff;
      off_angle_in  = off_angle_ff;

      // A calibration message records the offset and the current angle; turns, speed and ring hold.
      if (calib) begin
         rate          = '0;
         turns_in      = turns_ff;
         ptr_in        = ptr_ff;
         sum_in        = sum_ff;
         last_speed_in = last_speed_ff;
         off_angle_in  = s1_angle_ff;
      end

      // Total count, wrapping at 32 bits; 8192 counts per turn is a shift.
      total = {turns_in[CW-memt_pkg::DEG_SHIFT-1:0], {memt_pkg::DEG_SHIFT{1'b0}}}
              + {{(CW-AW){1'b0}}, cur_angle_in} - {{(CW-AW){1'b0}}, off_angle_in};

      // Degrees: total * 360 / 8192, rounded toward zero by biasing negatives.
      deg_prod   = DEG_W'($signed(total)) * $signed(DEG_W'(memt_pkg::DEG_SCALE));
      deg_biased = deg_prod + (deg_prod[DEG_W-1] ?
                   $signed(DEG_W'(memt_pkg::FULL_TURN - 1)) : $signed(DEG_W'(0)));
      degrees    = CW'(deg_biased >>> memt_pkg::DEG_SHIFT);

      // Ring average, truncated toward zero: divide the magnitude, restore sign.
      sum_mag  = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);
      avg_prod = PROD_W'(sum_mag) * PROD_W'(RCP_MUL);
      avg_mag  = RW'(avg_prod >> RCP_SH);
      avg      = sum_in[SUM_W-1] ? -$signed(avg_mag) : $signed(avg_mag);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msg_count_ff  <= '0;
         cur_angle_ff  <= '0;
         off_angle_ff  <= '0;
         turns_ff      <= '0;
         last_speed_ff <= '0;
         ptr_ff        <= '0;
         sum_ff        <= '0;
         for (int i = 0; i < AVERAGE_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (update) begin
         msg_count_ff  <= msg_count_in;
         cur_angle_ff  <= cur_angle_in;
         off_angle_ff  <= off_angle_in;
         turns_ff      <= turns_in;
         last_speed_ff <= last_speed_in;
         ptr_ff        <= ptr_in;
         sum_ff        <= sum_in;
         if (!calib) begin
            ring_ff[ptr_ff] <= rate;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result register.
   // ---------------------------------------------------------------------
   logic                                rsp_calibrating_ff;
   logic signed [memt_pkg::SPEED_W-1:0] rsp_speed_ff;
   logic signed [RW-1:0]                rsp_rate_ff;
   logic        [CW-1:0]                rsp_turns_ff;
   logic        [CW-1:0]                rsp_total_ff;
   logic        [CW-1:0]                rsp_degrees_ff;
   logic signed [RW-1:0]                rsp_avg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         rsp_calibrating_ff <= calib;
         rsp_speed_ff       <= last_speed_in;
         rsp_rate_ff        <= rate;
         rsp_turns_ff       <= turns_in;
         rsp_total_ff       <= total;
         rsp_degrees_ff     <= degrees;
         rsp_avg_ff         <= avg;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_calibrating   = rsp_calibrating_ff;
   assign rsp_last_speed    = rsp_speed_ff;
   assign rsp_step_rate     = rsp_rate_ff;
   assign rsp_turn_count    = $signed(rsp_turns_ff);
   assign rsp_total_count   = $signed(rsp_total_ff);
   assign rsp_total_degrees = $signed(rsp_degrees_ff);
   assign rsp_filtered_rate = rsp_avg_ff;

endmodule

// ===== src/memt_checker.sv =====
// Port-level checks for the multi-turn encoder tracker, bound to the top level.
// Depends on memt_pkg and motor_encoder_multiturn_tracker_defines.svh.
`include "motor_encoder_multiturn_tracker_defines.svh"

module memt_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_calibrating,
   input logic signed [memt_pkg::RATE_W-1:0]    rsp_step_rate,
   input logic signed [memt_pkg::RATE_W-1:0]    rsp_filtered_rate
);

   // A result offered under stall is still offered in the next cycle.
   `MEMT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid,
                     "rsp dropped under stall")

   // The result register is empty right after reset.
   `MEMT_ASSERT_SAME(a_rsp_reset, clock, 1'b0, $past(reset), !rsp_valid,
                     "rsp valid after reset")

   // A calibration message never reports motion.
   `MEMT_ASSERT_SAME(a_calib_rate, clock, reset, rsp_valid && rsp_calibrating,
                     rsp_step_rate == 0, "nonzero step during calibration")

   // The unwrapped step and its average stay within half a turn.
   `MEMT_ASSERT_SAME(a_rate_range, clock, reset, rsp_valid,
                     (rsp_step_rate >= -14'sd4096) && (rsp_step_rate <= 14'sd4096)
                     && (rsp_filtered_rate >= -14'sd4096)
                     && (rsp_filtered_rate <= 14'sd4096),
                     "step rate out of range")

endmodule

bind motor_encoder_multiturn_tracker memt_checker u_memt_checker (.*);

// ===== tb/tb_motor_encoder_multiturn_tracker.sv =====
// Self-checking testbench for motor_encoder_multiturn_tracker: directed and random feedback
// messages, a predictor of the tracker state and a per-field result scoreboard.
// Depends on memt_pkg and the tracker RTL only.
module tb_motor_encoder_multiturn_tracker;

   localparam int DEPTH          = memt_pkg::AVERAGE_DEPTH_DEF;
   localparam int IDLE_PCT       = 13;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 300;

   localparam int ANGLE_W   = memt_pkg::ANGLE_W;
   localparam int SPEED_W   = memt_pkg::SPEED_W;
   localparam int RATE_W    = memt_pkg::RATE_W;
   localparam int COUNT_W   = memt_pkg::COUNT_W;
   localparam int CAL_W     = memt_pkg::CAL_W;
   localparam int CSR_AW    = memt_pkg::CSR_AW;
   localparam int CSR_DW    = memt_pkg::CSR_DW;
   localparam int HALF_TURN = memt_pkg::HALF_TURN;
   localparam int FULL_TURN = memt_pkg::FULL_TURN;
   localparam int DEG_SCALE = memt_pkg::DEG_SCALE;
   localparam logic [CAL_W-1:0] CAL_RESET     = memt_pkg::CAL_RESET;
   localparam logic [CAL_W-1:0] MSG_COUNT_MAX = memt_pkg::MSG_COUNT_MAX;

   // One result transfer, with every field at the width of its port.
   typedef struct {
      logic                      calibrating;
      logic signed [SPEED_W-1:0] last_speed;
      logic signed [RATE_W-1:0]  step_rate;
      logic signed [COUNT_W-1:0] turn_count;
      logic signed [COUNT_W-1:0] total_count;
      logic signed [COUNT_W-1:0] total_degrees;
      logic signed [RATE_W-1:0]  filtered_rate;
   } tracker_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [ANGLE_W-1:0]        req_angle_raw;
   logic signed [SPEED_W-1:0] req_speed_raw;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_calibrating;
   logic signed [SPEED_W-1:0] rsp_last_speed;
   logic signed [RATE_W-1:0]  rsp_step_rate;
   logic signed [COUNT_W-1:0] rsp_turn_count;
   logic signed [COUNT_W-1:0] rsp_total_count;
   logic signed [COUNT_W-1:0] rsp_total_degrees;
   logic signed [RATE_W-1:0]  rsp_filtered_rate;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_AW-1:0]         paddr;
   logic [CSR_DW-1:0]         pwdata;
   logic [CSR_DW-1:0]         prdata;
   logic                      pready;

   // Predictor copy of the tracker state. Reset is applied once at the start of the run, so the
   // reset values are given right here and never loaded again.
   logic [CAL_W-1:0]          cal_setting = CAL_RESET;
   logic [CAL_W-1:0]          msg_count   = '0;
   logic [ANGLE_W-1:0]        cur_angle   = '0;
   logic [ANGLE_W-1:0]        zero_angle  = '0;
   logic [COUNT_W-1:0]        turn_acc    = '0;
   logic signed [RATE_W-1:0]  rate_hist [DEPTH];
   int                        hist_ptr    = 0;
   logic signed [SPEED_W-1:0] held_speed  = '0;

   // Results that have been predicted but not yet seen on the result channel, oldest first.
   tracker_result_type pending_results [$];
   tracker_result_type oldest_result;

   int                 mismatch_count = 0;
   int                 quiet_cycles   = 0;
   bit                 no_idle        = 1'b0;
   int                 velocity       = 0;
   logic [ANGLE_W-1:0] last_angle     = '0;

   motor_encoder_multiturn_tracker #(
      .AVERAGE_DEPTH(DEPTH)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_angle_raw    (req_angle_raw),
      .req_speed_raw    (req_speed_raw),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_calibrating  (rsp_calibrating),
      .rsp_last_speed   (rsp_last_speed),
      .rsp_step_rate    (rsp_step_rate),
      .rsp_turn_count   (rsp_turn_count),
      .rsp_total_count  (rsp_total_count),
      .rsp_total_degrees(rsp_total_degrees),
      .rsp_filtered_rate(rsp_filtered_rate),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      foreach (rate_hist[i]) rate_hist[i] = '0;
   end

   // Works out the result of one accepted message and advances the predictor state. A
   // calibration message only moves the current and zero angles; the held speed, the turn
   // counter and the rate history stay as they are, and the step rate reads zero.
   function automatic tracker_result_type track_message(input logic [ANGLE_W-1:0] angle,
                                                        input logic signed [SPEED_W-1:0] speed);
      tracker_result_type res;
      logic               calib;
      int                 diff;
      int                 rate;
      int                 sum;
      logic [COUNT_W-1:0] total_u;
      longint             deg;
      calib = (msg_count < cal_setting);
      if (msg_count != MSG_COUNT_MAX) begin
         msg_count = msg_count + 1'b1;
      end
      rate = 0;
      if (calib) begin
         cur_angle  = angle;
         zero_angle = angle;
      end else begin
         diff       = int'(angle) - int'(cur_angle);
         cur_angle  = angle;
         held_speed = speed;
         // A jump of more than half a turn is taken as a wrap through zero.
         if (diff > HALF_TURN) begin
            turn_acc = turn_acc - 1'b1;
            rate     = diff - FULL_TURN;
         end else if (diff < -HALF_TURN) begin
            turn_acc = turn_acc + 1'b1;
            rate     = diff + FULL_TURN;
         end else begin
            rate = diff;
         end
         rate_hist[hist_ptr] = RATE_W'(rate);
         hist_ptr = (hist_ptr == DEPTH - 1) ? 0 : hist_ptr + 1;
      end
      total_u = turn_acc * FULL_TURN + cur_angle - zero_angle;
      // The product is taken wide, so only the division truncates (toward zero).
      deg = (longint'($signed(total_u)) * DEG_SCALE) / FULL_TURN;
      sum = 0;
      foreach (rate_hist[i]) sum += rate_hist[i];
      res.calibrating   = calib;
      res.last_speed    = held_speed;
      res.step_rate     = RATE_W'(rate);
      res.turn_count    = turn_acc;
      res.total_count   = total_u;
      res.total_degrees = COUNT_W'(deg);
      res.filtered_rate = RATE_W'(sum / DEPTH);
      return res;
   endfunction

   task automatic check_field(input string field, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
   endtask

   // Result checker. Inputs are driven with nonblocking assignments, so rsp_stall read here is
   // the value that held at the edge; the same holds for the outputs of the tracker.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result transfer with no expectation waiting, expected none, got %0d",
                     $time, rsp_total_count);
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("calibrating", oldest_result.calibrating, rsp_calibrating);
            check_field("last_speed", oldest_result.last_speed, rsp_last_speed);
            check_field("step_rate", oldest_result.step_rate, rsp_step_rate);
            check_field("turn_count", oldest_result.turn_count, rsp_turn_count);
            check_field("total_count", oldest_result.total_count, rsp_total_count);
            check_field("total_degrees", oldest_result.total_degrees, rsp_total_degrees);
            check_field("filtered_rate", oldest_result.filtered_rate, rsp_filtered_rate);
         end
      end
   end

   // The receiver stalls at random, except during the stretch where both sides run flat out.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // Watchdog: any transfer on either channel or a register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (psel && penable && pwrite && pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Sends one message. Valid stays high from one transfer to the next unless an idle gap is
   // drawn, so valid is never lowered and raised again within one time step. The expectation is
   // recorded at the edge where the transfer happens.
   task automatic send_message(input logic [ANGLE_W-1:0] angle,
                               input logic signed [SPEED_W-1:0] speed);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_angle_raw <= angle;
      req_speed_raw <= speed;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(track_message(angle, speed));
      last_angle = angle;
   endtask

   // Drops valid and waits until every predicted result has arrived. Every message gives exactly
   // one result, so an empty queue means the tracker holds no work.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the access edge.
   task automatic csr_write(input memt_pkg::csr_index_type idx, input logic [CSR_DW-1:0] value);
      wait_idle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == memt_pkg::CSR_CALIBRATION) begin
         cal_setting = value[CAL_W-1:0];
      end
   endtask

   // Random message around the last angle sent. Most messages follow a smooth rotation at the
   // phase velocity so that the turn counter keeps moving; some land right on the half-turn
   // boundary, some repeat the angle, and the rest jump anywhere.
   task automatic random_message();
      logic [ANGLE_W-1:0]        angle;
      logic signed [SPEED_W-1:0] speed;
      int                        pick;
      int                        delta;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         delta = velocity + int'($urandom_range(0, 400)) - 200;
      end else if (pick < 70) begin
         delta = HALF_TURN - 1 + int'($urandom_range(0, 2));
         if ($urandom_range(0, 1) == 1) begin
            delta = -delta;
         end
      end else if (pick < 75) begin
         delta = 0;
      end else begin
         delta = int'($urandom_range(0, FULL_TURN - 1));
      end
      angle = ANGLE_W'(int'(last_angle) + delta);
      case ($urandom_range(0, 19))
         0: begin
            speed = 16'sh8000;
         end
         1: begin
            speed = 16'sh7fff;
         end
         2: begin
            speed = -16'sd1;
         end
         default: begin
            speed = SPEED_W'($urandom);
         end
      endcase
      send_message(angle, speed);
   endtask

   task automatic new_velocity();
      velocity = int'($urandom_range(0, 3000)) - 1500;
   endtask

   // With a zero calibration count set before the first message, tracking starts from the reset
   // angle and offset of zero. The steps hit both sides of the half-turn boundary and full-scale
   // wraps in each direction, and the angles and speeds cover the ends of their ranges.
   task automatic test_zero_calibration();
      csr_write(memt_pkg::CSR_CALIBRATION, '0);
      send_message(13'd0, 16'sd0);
      send_message(13'd4096, 16'sh7fff);
      send_message(13'd0, 16'sh8000);
      send_message(13'd4097, -16'sd1);
      send_message(13'd0, 16'sd1);
      send_message(13'd8191, 16'sh5555);
      send_message(13'd0, 16'shaaaa);
      send_message(13'd8191, 16'sh7fff);
      send_message(13'd8191, 16'sh8000);
      send_message(13'd2, 16'sd300);
   endtask

   // A write to the unused register index must not touch the calibration count: the messages
   // that follow are still tracked.
   task automatic test_ignored_index();
      csr_write(memt_pkg::CSR_UNUSED, 32'hffff_ffff);
      send_message(13'd100, 16'sd1200);
      send_message(13'd200, -16'sd1200);
      send_message(13'd50, 16'sd7);
   endtask

   // Raising the calibration count above the message count makes the next messages capture a
   // new offset while speed, turns and the rate history hold; tracking then resumes from it.
   task automatic test_recalibration();
      csr_write(memt_pkg::CSR_CALIBRATION, CSR_DW'(msg_count + 8'd5));
      send_message(13'd1234, 16'sd999);
      send_message(13'd7000, -16'sd999);
      send_message(13'd8191, 16'sh7fff);
      send_message(13'd0, 16'sh8000);
      send_message(13'd3000, 16'sd42);
      send_message(13'd7500, 16'sd500);
      send_message(13'd100, -16'sd500);
      send_message(13'd4196, 16'sd0);
      send_message(13'd3000, 16'sd1);
   endtask

   // Random messages with calibration counts at or just above the message count, so short runs
   // of calibration messages keep falling between tracked ones.
   task automatic test_random_calibration();
      int phase;
      int n;
      int setting;
      for (phase = 0; phase < 3; phase++) begin
         setting = int'(msg_count) + int'($urandom_range(0, 15));
         if (setting > int'(MSG_COUNT_MAX)) begin
            setting = int'(MSG_COUNT_MAX);
         end
         csr_write(memt_pkg::CSR_CALIBRATION, CSR_DW'(setting));
         new_velocity();
         for (n = 0; n < 25; n++) random_message();
      end
   endtask

   // At the largest calibration count every message calibrates until the counter saturates at
   // its top value; from then on every message is tracked.
   task automatic test_counter_saturation();
      int n;
      csr_write(memt_pkg::CSR_CALIBRATION, CSR_DW'(MSG_COUNT_MAX));
      new_velocity();
      while (msg_count != MSG_COUNT_MAX) random_message();
      for (n = 0; n < 30; n++) random_message();
   endtask

   // Long random runs of tracked messages under several calibration settings, one of them with
   // no idle cycles and no stalls at all.
   task automatic test_random_tracking();
      int               phase;
      int               n;
      logic [CAL_W-1:0] setting;
      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               setting = '0;
            end
            1: begin
               setting = MSG_COUNT_MAX;
            end
            default: begin
               setting = CAL_W'($urandom);
            end
         endcase
         csr_write(memt_pkg::CSR_CALIBRATION, CSR_DW'(setting));
         no_idle = (phase == 2);
         new_velocity();
         for (n = 0; n < PHASE_ITEMS; n++) random_message();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_angle_raw <= '0;
      req_speed_raw <= '0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_zero_calibration();
      test_ignored_index();
      test_recalibration();
      test_random_calibration();
      test_counter_saturation();
      test_random_tracking();

      // Two register stages sit between the channels; the extra wait catches any stray result.
      wait_idle();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
